// ----- src/tagged_sorted_log_index_unit_macros.svh -----
// Assertion macros used by the checker file of the log index unit.
`ifndef TAGGED_SORTED_LOG_INDEX_UNIT_MACROS_SVH
`define TAGGED_SORTED_LOG_INDEX_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TSLI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsli assertion failed");

// Next-cycle implication, disabled while in reset.
`define TSLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsli assertion failed");

`endif

// ----- src/tsli_pkg.sv -----
// Package of the log index unit: widths, codes and parameter defaults.
package tsli_pkg;

  localparam int ENTRIES_DEF = 1024;
  localparam int TAGS_DEF    = 2;

  localparam int MODE_W  = 2;
  localparam int LOW_W   = 32;
  localparam int ENG_W   = 16;
  localparam int TAG_W   = 64;
  localparam int SEQ_W   = 64;
  localparam int STAT_W  = 2;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PREV = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NEXT = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ORDER = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // register index of space_id
  localparam logic REG_SPACE_ID = 1'b0;

endpackage

// ----- src/tsli_if.sv -----
// Valid/ready channel interfaces for requests and results of the log index unit.
interface tsli_in_if import tsli_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [LOW_W-1:0]  entry_low;
  logic [ENG_W-1:0]  entry_engine;
  logic [TAG_W-1:0]  entry_tag_a;
  logic [TAG_W-1:0]  entry_tag_b;
  logic [SEQ_W-1:0]  probe_value;
  logic [TAG_W-1:0]  probe_tag;

  modport source (output valid, mode, entry_low, entry_engine, entry_tag_a, entry_tag_b,
                  probe_value, probe_tag, input ready);
  modport sink (input valid, mode, entry_low, entry_engine, entry_tag_a, entry_tag_b,
                probe_value, probe_tag, output ready);
endinterface

interface tsli_out_if import tsli_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SEQ_W-1:0]  hit_sequence;
  logic [ENG_W-1:0]  hit_engine;

  modport source (output valid, status, hit_sequence, hit_engine, input ready);
  modport sink (input valid, status, hit_sequence, hit_engine, output ready);
endinterface

// ----- src/tagged_sorted_log_index_unit.sv -----
// Top level of the tagged sorted log index: append-only store with predecessor/successor search.
//
// Usage:
//   in_ch carries one request per transaction: mode 0 appends an entry, mode 1 finds the
//   greatest entry at or below probe_value, mode 2 the least entry at or above it; a nonzero
//   probe_tag limits the search to entries carrying that tag. out_ch returns one result per
//   request: status, hit_sequence ({space_id, low half}) and hit_engine.
//   Write space_id at APB address 0 only with no request in flight; the block does not check.
// Timing:
//   One request at a time; in_ch.ready is high only in the idle state.
//   Add: the result passes through S_ADD and then S_OUT before out_ch.valid rises.
//   Search: each binary-search step over the stored entries (ceil(log2(fill+1))
//   steps, 11 for a full store) runs S_BS_RD then S_BS_CMP; each scanned candidate (one
//   without a tag filter) runs S_SC_RD then S_SC_CHK, and the result leaves via S_OUT;
//   every step waits on the registered RAM read port.
//   Mode 3 goes straight to S_OUT and returns "not found".
// Reset clears the state, the fill count, space_id and out_ch.valid; the entry RAMs are left
//   as they are and only data from slots below the fill count is ever used.
// A stalled out_ch holds its result; the next request is accepted meanwhile and its result
//   waits in the finishing state until the output register frees up.
module tagged_sorted_log_index_unit import tsli_pkg::*; #(
  parameter int ENTRIES        = ENTRIES_DEF,
  parameter int TAGS_PER_ENTRY = TAGS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  tsli_in_if.sink           in_ch,
  tsli_out_if.source        out_ch
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int TW = TAG_W * TAGS_PER_ENTRY;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ADD    = 3'd1;
  localparam logic [2:0] S_BS_RD  = 3'd2;
  localparam logic [2:0] S_BS_CMP = 3'd3;
  localparam logic [2:0] S_SC_RD  = 3'd4;
  localparam logic [2:0] S_SC_CHK = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  // control state
  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [LOW_W-1:0]  space_id_r, space_id_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload
  logic [LOW_W-1:0]  last_low_r, last_low_nxt;
  logic              prev_r, prev_nxt;
  logic [LOW_W-1:0]  low_r, low_nxt;
  logic [ENG_W-1:0]  eng_r, eng_nxt;
  logic [TAG_W-1:0]  tag_a_r, tag_a_nxt;
  logic [TAG_W-1:0]  tag_b_r, tag_b_nxt;
  logic [SEQ_W-1:0]  probe_r, probe_nxt;
  logic [TAG_W-1:0]  ptag_r, ptag_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [SEQ_W-1:0]  res_seq_r, res_seq_nxt;
  logic [ENG_W-1:0]  res_eng_r, res_eng_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [SEQ_W-1:0]  out_seq_r, out_seq_nxt;
  logic [ENG_W-1:0]  out_eng_r, out_eng_nxt;

  // memory side
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [TW-1:0]     tag_wdata;
  logic [LOW_W-1:0]  low_rd;
  logic [ENG_W-1:0]  eng_rd;
  logic [TW-1:0]     tag_rd;

  logic [CW:0]       mid_sum;
  logic [AW-1:0]     mid;
  logic [CW-1:0]     lo_dec;
  logic [AW-1:0]     scan_addr;
  logic [SEQ_W-1:0]  ent_full;
  logic              ent_below;
  logic              tag_hit;
  logic              in_acc;
  logic              cfg_wr;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = mid_sum[AW:1];
  assign lo_dec   = lo_r - CW'(1);
  assign scan_addr = prev_r ? lo_dec[AW-1:0] : lo_r[AW-1:0];
  assign mem_raddr = (state_r == S_BS_RD) ? mid : scan_addr;
  assign mem_waddr = fill_r[AW-1:0];

  assign ent_full  = {space_id_r, low_rd};
  // prev: count entries <= probe; next: count entries < probe
  assign ent_below = prev_r ? (ent_full <= probe_r) : (ent_full < probe_r);

  always_comb begin
    tag_wdata = '0;
    for (int t = 0; t < TAGS_PER_ENTRY; t++) begin
      if (t == 0) begin
        tag_wdata[t*TAG_W +: TAG_W] = tag_a_r;
      end else if (t == 1) begin
        tag_wdata[t*TAG_W +: TAG_W] = tag_b_r;
      end
    end
  end

  // stored zero tags never match since a zero probe tag bypasses the filter
  always_comb begin
    tag_hit = (ptag_r == '0);
    for (int t = 0; t < TAGS_PER_ENTRY; t++) begin
      if (tag_rd[t*TAG_W +: TAG_W] == ptag_r) begin
        tag_hit = 1'b1;
      end
    end
  end

  // APB config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_SPACE_ID) ? space_id_r : '0;
  assign space_id_nxt = (cfg_wr && paddr[2] == REG_SPACE_ID) ? pwdata : space_id_r;

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    last_low_nxt   = last_low_r;
    prev_nxt       = prev_r;
    low_nxt        = low_r;
    eng_nxt        = eng_r;
    tag_a_nxt      = tag_a_r;
    tag_b_nxt      = tag_b_r;
    probe_nxt      = probe_r;
    ptag_nxt       = ptag_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    res_status_nxt = res_status_r;
    res_seq_nxt    = res_seq_r;
    res_eng_nxt    = res_eng_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_seq_nxt    = out_seq_r;
    out_eng_nxt    = out_eng_r;
    mem_we         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          prev_nxt       = (in_ch.mode == MODE_PREV);
          low_nxt        = in_ch.entry_low;
          eng_nxt        = in_ch.entry_engine;
          tag_a_nxt      = in_ch.entry_tag_a;
          tag_b_nxt      = in_ch.entry_tag_b;
          probe_nxt      = in_ch.probe_value;
          ptag_nxt       = in_ch.probe_tag;
          lo_nxt         = '0;
          hi_nxt         = fill_r;
          res_status_nxt = ST_MISS;
          res_seq_nxt    = '0;
          res_eng_nxt    = '0;
          case (in_ch.mode)
            MODE_ADD:              state_nxt = S_ADD;
            MODE_PREV, MODE_NEXT:  state_nxt = S_BS_RD;
            default:               state_nxt = S_OUT;
          endcase
        end
      end
      S_ADD: begin
        state_nxt = S_OUT;
        if (fill_r == CW'(ENTRIES)) begin
          res_status_nxt = ST_FULL;
        end else if (fill_r != '0 && low_r <= last_low_r) begin
          res_status_nxt = ST_ORDER;
        end else begin
          res_status_nxt = ST_OK;
          mem_we         = 1'b1;
          fill_nxt       = fill_r + CW'(1);
          last_low_nxt   = low_r;
        end
      end
      S_BS_RD: begin
        state_nxt = (lo_r == hi_r) ? S_SC_RD : S_BS_CMP;
      end
      S_BS_CMP: begin
        state_nxt = S_BS_RD;
        if (ent_below) begin
          lo_nxt = CW'(mid) + CW'(1);
        end else begin
          hi_nxt = CW'(mid);
        end
      end
      S_SC_RD: begin
        if (prev_r ? (lo_r == '0) : (lo_r == fill_r)) begin
          state_nxt = S_OUT;
        end else begin
          lo_nxt    = prev_r ? lo_dec : lo_r + CW'(1);
          state_nxt = S_SC_CHK;
        end
      end
      S_SC_CHK: begin
        if (tag_hit) begin
          res_status_nxt = ST_OK;
          res_seq_nxt    = ent_full;
          res_eng_nxt    = eng_rd;
          state_nxt      = S_OUT;
        end else begin
          state_nxt = S_SC_RD;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_seq_nxt    = res_seq_r;
          out_eng_nxt    = res_eng_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      space_id_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      space_id_r  <= space_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_low_r   <= last_low_nxt;
    prev_r       <= prev_nxt;
    low_r        <= low_nxt;
    eng_r        <= eng_nxt;
    tag_a_r      <= tag_a_nxt;
    tag_b_r      <= tag_b_nxt;
    probe_r      <= probe_nxt;
    ptag_r       <= ptag_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    res_status_r <= res_status_nxt;
    res_seq_r    <= res_seq_nxt;
    res_eng_r    <= res_eng_nxt;
    out_status_r <= out_status_nxt;
    out_seq_r    <= out_seq_nxt;
    out_eng_r    <= out_eng_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.hit_sequence = out_seq_r;
  assign out_ch.hit_engine   = out_eng_r;

  tsli_ram #(.WIDTH(LOW_W), .DEPTH(ENTRIES)) u_low_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (low_r),
    .raddr (mem_raddr),
    .rdata (low_rd)
  );

  tsli_ram #(.WIDTH(ENG_W), .DEPTH(ENTRIES)) u_eng_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (eng_r),
    .raddr (mem_raddr),
    .rdata (eng_rd)
  );

  // all tag slots of an entry sit side by side in one row
  tsli_ram #(.WIDTH(TW), .DEPTH(ENTRIES)) u_tag_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (tag_wdata),
    .raddr (mem_raddr),
    .rdata (tag_rd)
  );

endmodule

// ----- src/tsli_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tsli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/tsli_chk.sv -----
// Port-level checker of the log index unit and its bind to the top level.
`include "tagged_sorted_log_index_unit_macros.svh"

module tsli_chk import tsli_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] out_status,
  input logic [SEQ_W-1:0]  out_hit_sequence,
  input logic [ENG_W-1:0]  out_hit_engine
);

  // a stalled result holds its status
  `TSLI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status))

  // anything but a hit carries zero hit fields
  `TSLI_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && out_status != ST_OK, out_hit_sequence == '0 && out_hit_engine == '0)

  // one transaction at a time: busy right after acceptance
  `TSLI_ASSERT_NEXT(a_busy_after_acc, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind tagged_sorted_log_index_unit tsli_chk u_tsli_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_hit_sequence (out_ch.hit_sequence),
  .out_hit_engine   (out_ch.hit_engine)
);
